/* src/dhcl_pkg.sv */
// Types, codes and constants shared by the DHCP client lease state machine.
package dhcl_pkg;

    // Client states, encoded as reported on the result channel
    typedef enum logic [2:0] {
        ST_SELECTING  = 3'd0,
        ST_REQUESTING = 3'd1,
        ST_BOUND      = 3'd2,
        ST_RENEWING   = 3'd3,
        ST_REBINDING  = 3'd4,
        ST_RENEW_REQ  = 3'd5,
        ST_RELEASED   = 3'd6
    } t_state;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PACKET  = 2'd1,
        OP_RENEW   = 2'd2,
        OP_RELEASE = 2'd3
    } t_opcode;

    // Listen modes
    typedef enum logic [1:0] {
        LM_NONE   = 2'd0,
        LM_KERNEL = 2'd1,
        LM_RAW    = 2'd2
    } t_listen;

    // Packets to send
    typedef enum logic [2:0] {
        SK_NONE      = 3'd0,
        SK_DISCOVER  = 3'd1,
        SK_SELECT    = 3'd2,
        SK_RENEW_UNI = 3'd3,
        SK_RENEW_BC  = 3'd4,
        SK_RELEASE   = 3'd5
    } t_send;

    // Script events
    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_DECONFIG     = 3'd1,
        EV_BOUND        = 3'd2,
        EV_RENEW        = 3'd3,
        EV_NAK          = 3'd4,
        EV_NAK_DECONFIG = 3'd5
    } t_event;

    // Message type codes of a received packet
    localparam logic [2:0] MK_ABSENT = 3'd0;
    localparam logic [2:0] MK_OFFER  = 3'd1;
    localparam logic [2:0] MK_ACK    = 3'd2;
    localparam logic [2:0] MK_NAK    = 3'd3;

    // Timing constants in seconds, then the retry limits
    localparam logic [31:0] RELEASED_WAIT   = 32'h7fff_ffff;
    localparam logic [31:0] DEFAULT_LEASE   = 32'd3600;
    localparam logic [31:0] RETRY_SHORT     = 32'd2;
    localparam logic [31:0] DISCOVER_LAST   = 32'd4;
    localparam logic [31:0] REQUEST_LAST    = 32'd10;
    localparam logic [31:0] EXHAUSTED_WAIT  = 32'd20;
    localparam logic [1:0]  MAX_TRIES       = 2'd3;
    localparam logic [1:0]  LAST_TRY        = 2'd2;

    // lease / 14400 = (lease >> 6) / 225, done as a multiply by 2^34 / 225 rounded up
    localparam int          GRAIN_SHIFT = 6;
    localparam int          RECIP_SHIFT = 34;
    localparam int          RECIP_W     = 27;
    localparam int          QUOT_W      = 19;
    localparam logic [RECIP_W-1:0] GRAIN_RECIP = 27'd76354975;

    // Input and output channel tdata widths
    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 144;

    // One input item
    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] now_seconds;
        logic [31:0] fresh_id;
        logic [31:0] packet_id;
        logic [2:0]  message_kind;
        logic        has_server_id;
        logic [31:0] server_id;
        logic [31:0] offered_address;
        logic        has_lease;
        logic [31:0] lease_option;
    } t_item;

    // One result item
    typedef struct packed {
        t_send       send_kind;
        logic [31:0] send_id;
        logic [31:0] send_server;
        logic [31:0] send_address;
        t_event      script_kind;
        t_state      client_state;
        t_listen     sock_mode;
        logic [31:0] lease_seconds;
        logic        lease_exhausted;
    } t_result;

endpackage

/* src/dhcp_client_lease_fsm.sv */
// DHCP client lease state machine: input register, one-pass update logic, result register.
//
// Usage:
//   Slave channel (i_s_*): one beat per event. tuser carries the opcode (tick, packet
//   received, renew request, release request); tdata carries the time, a fresh
//   transaction id and the parsed reply fields.
//   Master channel (o_m_*): exactly one result beat per input beat, in order. tuser
//   carries the packet kind to send; tdata carries the packet fields, the script event,
//   the new client state, listen mode, lease length and the lease-exhausted flag.
//   Config channel (i_cfg_*): writes the address requested in discover; the write also
//   loads the requested address at once. Write only while the block is idle.
// Timing:
//   An input beat lands in the input register; the whole update runs from there and
//   loads the result register once that is free, and the result is offered from it.
//   One beat per cycle is sustained while results are taken: the state update is a single
//   pass of logic fed by the input register, and the state is registered on each update.
// Reset:
//   Synchronous, active low. The client starts in selecting with raw listening and a
//   deadline of zero, so the first tick sends a discover. Both registers empty.
// Stall:
//   While i_m_tready is low the result holds; one more input beat is taken into the
//   input register, after which o_s_tready drops until the result is taken.
module dhcp_client_lease_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Fields low to high: now_seconds[31:0], fresh_id[63:32], packet_id[95:64],
    // message_kind[98:96], has_server_id[99], server_id[131:100],
    // offered_address[163:132], has_lease[164], lease_option[196:165], zero pad
    input  logic [dhcl_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic [1:0]                          i_s_tuser,   // opcode[1:0]
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // Fields low to high: send_id[31:0], send_server[63:32], send_address[95:64],
    // script_kind[98:96], client_state[101:99], sock_mode[103:102],
    // lease_seconds[135:104], lease_exhausted[136], zero pad
    output logic [dhcl_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic [2:0]                          o_m_tuser,   // send_kind[2:0]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // Requested address register write
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready
);

    // Handshake and pipeline registers
    logic                       r_in_valid;
    dhcl_pkg::t_item            r_in;
    logic                       r_out_valid;
    dhcl_pkg::t_result          r_out;
    dhcl_pkg::t_result          n_out;
    logic                       w_advance;
    logic                       w_fire;

    // Client state
    dhcl_pkg::t_state           r_state,      n_state;
    logic [1:0]                 r_tries,      n_tries;
    logic [31:0]                r_deadline,   n_deadline;
    logic [31:0]                r_trans_id,   n_trans_id;
    logic [31:0]                r_srv_addr,   n_srv_addr;
    logic [31:0]                r_want_ip,    n_want_ip;
    logic [31:0]                r_renew_pt,   n_renew_pt;
    logic [31:0]                r_rebind_pt,  n_rebind_pt;
    logic [31:0]                r_lease_len,  n_lease_len;
    logic [31:0]                r_bound_at,   n_bound_at;
    dhcl_pkg::t_listen          r_listen,     n_listen;
    logic [dhcl_pkg::QUOT_W-1:0] r_grain_q,   n_grain_q;

    // Ack-side lease arithmetic
    logic [31:0]                w_lease;
    logic [34:0]                w_lease_x7;
    logic [dhcl_pkg::RECIP_W+25:0] w_quot_prod;
    logic [31:0]                w_margin;

    // Handshakes: the result register frees when empty or taken
    assign w_advance   = !r_out_valid || i_m_tready;
    assign w_fire      = r_in_valid && w_advance;
    assign o_s_tready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // Drive the master channel from the result register
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.send_kind;
    assign o_m_tdata  = {7'd0, r_out.lease_exhausted, r_out.lease_seconds,
                         r_out.sock_mode, r_out.client_state, r_out.script_kind,
                         r_out.send_address, r_out.send_server, r_out.send_id};

    // Lease chosen by an ack, its T2 point and its renew margin quotient
    assign w_lease     = r_in.has_lease ? r_in.lease_option : dhcl_pkg::DEFAULT_LEASE;
    assign w_lease_x7  = {w_lease, 3'd0} - {3'd0, w_lease};
    assign w_quot_prod = (dhcl_pkg::RECIP_W + 26)'(w_lease[31:dhcl_pkg::GRAIN_SHIFT])
                       * (dhcl_pkg::RECIP_W + 26)'(dhcl_pkg::GRAIN_RECIP);
    assign w_margin    = 32'(r_grain_q) + 32'd1;

    // Run one item against the current state
    always_comb begin
        logic [31:0] gap;
        logic [31:0] half_pt;
        logic        pkt_ok;

        n_state     = r_state;
        n_tries     = r_tries;
        n_deadline  = r_deadline;
        n_trans_id  = r_trans_id;
        n_srv_addr  = r_srv_addr;
        n_want_ip   = r_want_ip;
        n_renew_pt  = r_renew_pt;
        n_rebind_pt = r_rebind_pt;
        n_lease_len = r_lease_len;
        n_bound_at  = r_bound_at;
        n_listen    = r_listen;
        n_grain_q   = r_grain_q;

        n_out                 = '0;
        n_out.send_kind       = dhcl_pkg::SK_NONE;
        n_out.script_kind     = dhcl_pkg::EV_NONE;
        n_out.client_state    = r_state;
        n_out.sock_mode       = r_listen;

        gap     = '0;
        half_pt = '0;
        pkt_ok  = (r_listen != dhcl_pkg::LM_NONE) && (r_in.packet_id == r_trans_id)
               && (r_in.message_kind != dhcl_pkg::MK_ABSENT);

        unique case (r_in.opcode)
            dhcl_pkg::OP_TICK: begin
                if (r_in.now_seconds >= r_deadline) begin
                    unique case (r_state)
                        dhcl_pkg::ST_SELECTING: begin
                            if (r_tries < dhcl_pkg::MAX_TRIES) begin
                                if (r_tries == 2'd0) begin
                                    n_trans_id = r_in.fresh_id;
                                end
                                n_out.send_kind    = dhcl_pkg::SK_DISCOVER;
                                n_out.send_id      = n_trans_id;
                                n_out.send_address = r_want_ip;
                                n_deadline = r_in.now_seconds
                                    + ((r_tries == dhcl_pkg::LAST_TRY) ?
                                       dhcl_pkg::DISCOVER_LAST : dhcl_pkg::RETRY_SHORT);
                                n_tries = r_tries + 2'd1;
                            end else begin
                                n_tries    = '0;
                                n_deadline = r_in.now_seconds + dhcl_pkg::EXHAUSTED_WAIT;
                                n_out.lease_exhausted = 1'b1;
                            end
                        end
                        dhcl_pkg::ST_REQUESTING, dhcl_pkg::ST_RENEW_REQ: begin
                            if (r_tries < dhcl_pkg::MAX_TRIES) begin
                                if (r_state == dhcl_pkg::ST_RENEW_REQ) begin
                                    n_trans_id      = r_in.fresh_id;
                                    n_out.send_kind = dhcl_pkg::SK_RENEW_UNI;
                                end else begin
                                    n_out.send_kind = dhcl_pkg::SK_SELECT;
                                end
                                n_out.send_id      = n_trans_id;
                                n_out.send_server  = r_srv_addr;
                                n_out.send_address = r_want_ip;
                                n_deadline = r_in.now_seconds
                                    + ((r_tries == dhcl_pkg::LAST_TRY) ?
                                       dhcl_pkg::REQUEST_LAST : dhcl_pkg::RETRY_SHORT);
                                n_tries = r_tries + 2'd1;
                            end else begin
                                if (r_state == dhcl_pkg::ST_RENEW_REQ) begin
                                    n_out.script_kind = dhcl_pkg::EV_DECONFIG;
                                end
                                n_state    = dhcl_pkg::ST_SELECTING;
                                n_deadline = r_in.now_seconds;
                                n_tries    = '0;
                                n_listen   = dhcl_pkg::LM_RAW;
                            end
                        end
                        dhcl_pkg::ST_BOUND, dhcl_pkg::ST_RENEWING: begin
                            if (r_state == dhcl_pkg::ST_BOUND) begin
                                n_listen = dhcl_pkg::LM_KERNEL;
                            end
                            n_state = dhcl_pkg::ST_RENEWING;
                            gap     = r_rebind_pt - r_renew_pt;
                            if (gap <= w_margin) begin
                                n_state    = dhcl_pkg::ST_REBINDING;
                                n_deadline = r_in.now_seconds + gap;
                            end else begin
                                n_trans_id         = r_in.fresh_id;
                                n_out.send_kind    = dhcl_pkg::SK_RENEW_UNI;
                                n_out.send_id      = r_in.fresh_id;
                                n_out.send_server  = r_srv_addr;
                                n_out.send_address = r_want_ip;
                                half_pt    = (gap >> 1) + r_renew_pt;
                                n_renew_pt = half_pt;
                                n_deadline = half_pt + r_bound_at;
                            end
                        end
                        dhcl_pkg::ST_REBINDING: begin
                            gap = r_lease_len - r_rebind_pt;
                            if (gap <= w_margin) begin
                                n_out.script_kind = dhcl_pkg::EV_DECONFIG;
                                n_state    = dhcl_pkg::ST_SELECTING;
                                n_deadline = r_in.now_seconds;
                                n_tries    = '0;
                                n_listen   = dhcl_pkg::LM_RAW;
                            end else begin
                                n_trans_id         = r_in.fresh_id;
                                n_out.send_kind    = dhcl_pkg::SK_RENEW_BC;
                                n_out.send_id      = r_in.fresh_id;
                                n_out.send_address = r_want_ip;
                                half_pt     = (gap >> 1) + r_rebind_pt;
                                n_rebind_pt = half_pt;
                                n_deadline  = half_pt + r_bound_at;
                            end
                        end
                        dhcl_pkg::ST_RELEASED: begin
                            n_deadline = dhcl_pkg::RELEASED_WAIT;
                        end
                        default: begin
                            n_deadline = r_deadline;
                        end
                    endcase
                end
            end
            dhcl_pkg::OP_PACKET: begin
                if (pkt_ok) begin
                    unique case (r_state)
                        dhcl_pkg::ST_SELECTING: begin
                            if (r_in.message_kind == dhcl_pkg::MK_OFFER
                                && r_in.has_server_id) begin
                                n_srv_addr = r_in.server_id;
                                n_trans_id = r_in.packet_id;
                                n_want_ip  = r_in.offered_address;
                                n_state    = dhcl_pkg::ST_REQUESTING;
                                n_deadline = r_in.now_seconds;
                                n_tries    = '0;
                            end
                        end
                        dhcl_pkg::ST_REQUESTING, dhcl_pkg::ST_RENEW_REQ,
                        dhcl_pkg::ST_RENEWING, dhcl_pkg::ST_REBINDING: begin
                            if (r_in.message_kind == dhcl_pkg::MK_ACK) begin
                                n_lease_len = w_lease;
                                n_renew_pt  = w_lease >> 1;
                                n_rebind_pt = w_lease_x7[34:3];
                                n_grain_q   = w_quot_prod[dhcl_pkg::RECIP_SHIFT +: dhcl_pkg::QUOT_W];
                                n_bound_at  = r_in.now_seconds;
                                n_deadline  = (w_lease >> 1) + r_in.now_seconds;
                                n_want_ip   = r_in.offered_address;
                                n_out.script_kind =
                                    (r_state == dhcl_pkg::ST_RENEWING
                                     || r_state == dhcl_pkg::ST_REBINDING) ?
                                    dhcl_pkg::EV_RENEW : dhcl_pkg::EV_BOUND;
                                n_state  = dhcl_pkg::ST_BOUND;
                                n_listen = dhcl_pkg::LM_NONE;
                            end else if (r_in.message_kind == dhcl_pkg::MK_NAK) begin
                                n_out.script_kind = (r_state == dhcl_pkg::ST_REQUESTING) ?
                                    dhcl_pkg::EV_NAK : dhcl_pkg::EV_NAK_DECONFIG;
                                n_want_ip  = '0;
                                n_state    = dhcl_pkg::ST_SELECTING;
                                n_deadline = r_in.now_seconds;
                                n_tries    = '0;
                                n_listen   = dhcl_pkg::LM_RAW;
                            end
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
            end
            dhcl_pkg::OP_RENEW: begin
                unique case (r_state)
                    dhcl_pkg::ST_BOUND: begin
                        n_listen = dhcl_pkg::LM_KERNEL;
                        n_state  = dhcl_pkg::ST_RENEW_REQ;
                    end
                    dhcl_pkg::ST_RENEWING, dhcl_pkg::ST_REBINDING: begin
                        n_state = dhcl_pkg::ST_RENEW_REQ;
                    end
                    dhcl_pkg::ST_RENEW_REQ: begin
                        n_out.script_kind = dhcl_pkg::EV_DECONFIG;
                        n_listen = dhcl_pkg::LM_RAW;
                        n_state  = dhcl_pkg::ST_SELECTING;
                    end
                    dhcl_pkg::ST_REQUESTING, dhcl_pkg::ST_RELEASED: begin
                        n_listen = dhcl_pkg::LM_RAW;
                        n_state  = dhcl_pkg::ST_SELECTING;
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
                n_tries    = '0;
                n_deadline = '0;
            end
            dhcl_pkg::OP_RELEASE: begin
                if (r_state == dhcl_pkg::ST_BOUND || r_state == dhcl_pkg::ST_RENEWING
                    || r_state == dhcl_pkg::ST_REBINDING) begin
                    n_out.send_kind    = dhcl_pkg::SK_RELEASE;
                    n_out.send_id      = r_in.fresh_id;
                    n_out.send_server  = r_srv_addr;
                    n_out.send_address = r_want_ip;
                    n_out.script_kind  = dhcl_pkg::EV_DECONFIG;
                end
                n_listen   = dhcl_pkg::LM_NONE;
                n_state    = dhcl_pkg::ST_RELEASED;
                n_deadline = dhcl_pkg::RELEASED_WAIT;
            end
            default: begin
                n_state = r_state;
            end
        endcase

        n_out.client_state  = n_state;
        n_out.sock_mode     = n_listen;
        n_out.lease_seconds = n_lease_len;
    end

    // Hold control state: valid flags and the client state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= dhcl_pkg::ST_SELECTING;
            r_tries     <= '0;
            r_deadline  <= '0;
            r_trans_id  <= '0;
            r_srv_addr  <= '0;
            r_want_ip   <= '0;
            r_renew_pt  <= '0;
            r_rebind_pt <= '0;
            r_lease_len <= '0;
            r_bound_at  <= '0;
            r_listen    <= dhcl_pkg::LM_RAW;
            r_grain_q   <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_state     <= n_state;
                r_tries     <= n_tries;
                r_deadline  <= n_deadline;
                r_trans_id  <= n_trans_id;
                r_srv_addr  <= n_srv_addr;
                r_renew_pt  <= n_renew_pt;
                r_rebind_pt <= n_rebind_pt;
                r_lease_len <= n_lease_len;
                r_bound_at  <= n_bound_at;
                r_listen    <= n_listen;
                r_grain_q   <= n_grain_q;
            end
            // Load the requested address from the config beat, else from the update
            if (i_cfg_valid) begin
                r_want_ip <= i_cfg_data;
            end else if (w_fire) begin
                r_want_ip <= n_want_ip;
            end
        end
    end

    // Capture the input beat and the result payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.opcode          <= dhcl_pkg::t_opcode'(i_s_tuser);
            r_in.now_seconds     <= i_s_tdata[31:0];
            r_in.fresh_id        <= i_s_tdata[63:32];
            r_in.packet_id       <= i_s_tdata[95:64];
            r_in.message_kind    <= i_s_tdata[98:96];
            r_in.has_server_id   <= i_s_tdata[99];
            r_in.server_id       <= i_s_tdata[131:100];
            r_in.offered_address <= i_s_tdata[163:132];
            r_in.has_lease       <= i_s_tdata[164];
            r_in.lease_option    <= i_s_tdata[196:165];
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    // Listen is off exactly while bound or released
    a_listen_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_listen == dhcl_pkg::LM_NONE) ==
        (r_state == dhcl_pkg::ST_BOUND || r_state == dhcl_pkg::ST_RELEASED))
        else $error("listen mode out of step with client state");

    // A release beat always deconfigures and ends released
    a_release_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.send_kind == dhcl_pkg::SK_RELEASE) |->
        (r_out.script_kind == dhcl_pkg::EV_DECONFIG
         && r_out.client_state == dhcl_pkg::ST_RELEASED))
        else $error("release packet without deconfig in released state");

    // Exhausted discovers send nothing and stay selecting
    a_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.lease_exhausted) |->
        (r_out.send_kind == dhcl_pkg::SK_NONE
         && r_out.client_state == dhcl_pkg::ST_SELECTING))
        else $error("lease exhausted outside selecting");

    // A processed item shows up as a result on the next cycle
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed item lost before the result register");

    // Retry count never runs past three
    a_tries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tries <= dhcl_pkg::MAX_TRIES)
        else $error("retry count overflow");

endmodule

/* tb/dhcp_client_lease_fsm_tb.sv */
// Self-checking testbench for the DHCP client lease state machine: directed and random events.
module dhcp_client_lease_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] LEASE_GRAIN = 32'd14400;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          PHASES      = 4;
    localparam int          RANDOM_PER_PHASE = 200;

    // Tracks the client as the block should see it and holds the replies still owed
    class lease_tracker;
        dhcl_pkg::t_state   st;
        dhcl_pkg::t_listen  listen;
        logic [1:0]         tries;
        logic [31:0]        deadline;
        logic [31:0]        trans_id;
        logic [31:0]        srv_addr;
        logic [31:0]        want_ip;
        logic [31:0]        renew_pt;
        logic [31:0]        rebind_pt;
        logic [31:0]        lease_len;
        logic [31:0]        bound_at;
        dhcl_pkg::t_result  reply;
        dhcl_pkg::t_result  replies[$];
        int                 mismatches;

        function new();
            st         = dhcl_pkg::ST_SELECTING;
            listen     = dhcl_pkg::LM_RAW;
            tries      = '0;
            deadline   = '0;
            trans_id   = '0;
            srv_addr   = '0;
            want_ip    = '0;
            renew_pt   = '0;
            rebind_pt  = '0;
            lease_len  = '0;
            bound_at   = '0;
            mismatches = 0;
        endfunction

        // The register write also reloads the requested address
        function void set_request_ip(logic [31:0] v);
            want_ip = v;
        endfunction

        function void emit(dhcl_pkg::t_send kind, logic [31:0] id, logic [31:0] srv,
                           logic [31:0] addr);
            reply.send_kind    = kind;
            reply.send_id      = id;
            reply.send_server  = srv;
            reply.send_address = addr;
        endfunction

        function void to_selecting(logic [31:0] now);
            st       = dhcl_pkg::ST_SELECTING;
            deadline = now;
            tries    = '0;
            listen   = dhcl_pkg::LM_RAW;
        endfunction

        function void on_tick(logic [31:0] now, logic [31:0] fresh);
            logic [31:0] gap;
            logic [31:0] margin;
            if (now < deadline) return;
            margin = lease_len / LEASE_GRAIN + 32'd1;
            case (st)
                dhcl_pkg::ST_SELECTING: begin
                    if (tries < dhcl_pkg::MAX_TRIES) begin
                        if (tries == 2'd0) trans_id = fresh;
                        emit(dhcl_pkg::SK_DISCOVER, trans_id, '0, want_ip);
                        deadline = now + ((tries == dhcl_pkg::LAST_TRY) ?
                                          dhcl_pkg::DISCOVER_LAST : dhcl_pkg::RETRY_SHORT);
                        tries++;
                    end else begin
                        tries = '0;
                        deadline = now + dhcl_pkg::EXHAUSTED_WAIT;
                        reply.lease_exhausted = 1'b1;
                    end
                end
                dhcl_pkg::ST_RENEW_REQ, dhcl_pkg::ST_REQUESTING: begin
                    if (tries < dhcl_pkg::MAX_TRIES) begin
                        if (st == dhcl_pkg::ST_RENEW_REQ) begin
                            trans_id = fresh;
                            emit(dhcl_pkg::SK_RENEW_UNI, trans_id, srv_addr, want_ip);
                        end else begin
                            emit(dhcl_pkg::SK_SELECT, trans_id, srv_addr, want_ip);
                        end
                        deadline = now + ((tries == dhcl_pkg::LAST_TRY) ?
                                          dhcl_pkg::REQUEST_LAST : dhcl_pkg::RETRY_SHORT);
                        tries++;
                    end else begin
                        if (st == dhcl_pkg::ST_RENEW_REQ) reply.script_kind = dhcl_pkg::EV_DECONFIG;
                        to_selecting(now);
                    end
                end
                dhcl_pkg::ST_BOUND, dhcl_pkg::ST_RENEWING: begin
                    if (st == dhcl_pkg::ST_BOUND) begin
                        st = dhcl_pkg::ST_RENEWING;
                        listen = dhcl_pkg::LM_KERNEL;
                    end
                    gap = rebind_pt - renew_pt;
                    if (gap <= margin) begin
                        st = dhcl_pkg::ST_REBINDING;
                        deadline = now + gap;
                    end else begin
                        trans_id = fresh;
                        emit(dhcl_pkg::SK_RENEW_UNI, trans_id, srv_addr, want_ip);
                        renew_pt = (gap >> 1) + renew_pt;
                        deadline = renew_pt + bound_at;
                    end
                end
                dhcl_pkg::ST_REBINDING: begin
                    gap = lease_len - rebind_pt;
                    if (gap <= margin) begin
                        reply.script_kind = dhcl_pkg::EV_DECONFIG;
                        to_selecting(now);
                    end else begin
                        trans_id = fresh;
                        emit(dhcl_pkg::SK_RENEW_BC, trans_id, '0, want_ip);
                        rebind_pt = (gap >> 1) + rebind_pt;
                        deadline = rebind_pt + bound_at;
                    end
                end
                dhcl_pkg::ST_RELEASED: deadline = dhcl_pkg::RELEASED_WAIT;
                default: ;
            endcase
        endfunction

        function void on_packet(dhcl_pkg::t_item it);
            logic [31:0] lease;
            logic [34:0] wide;
            if (listen == dhcl_pkg::LM_NONE || it.packet_id != trans_id
                || it.message_kind == dhcl_pkg::MK_ABSENT)
                return;
            case (st)
                dhcl_pkg::ST_SELECTING: begin
                    if (it.message_kind == dhcl_pkg::MK_OFFER && it.has_server_id) begin
                        srv_addr = it.server_id;
                        trans_id = it.packet_id;
                        want_ip  = it.offered_address;
                        st       = dhcl_pkg::ST_REQUESTING;
                        deadline = it.now_seconds;
                        tries    = '0;
                    end
                end
                dhcl_pkg::ST_RENEW_REQ, dhcl_pkg::ST_REQUESTING,
                dhcl_pkg::ST_RENEWING, dhcl_pkg::ST_REBINDING: begin
                    if (it.message_kind == dhcl_pkg::MK_ACK) begin
                        lease     = it.has_lease ? it.lease_option : dhcl_pkg::DEFAULT_LEASE;
                        lease_len = lease;
                        renew_pt  = lease >> 1;
                        // T2 = 7/8 of the lease, product kept at 35 bits
                        wide      = ({3'b000, lease} * 35'd7) >> 3;
                        rebind_pt = wide[31:0];
                        bound_at  = it.now_seconds;
                        deadline  = renew_pt + it.now_seconds;
                        want_ip   = it.offered_address;
                        reply.script_kind =
                            (st == dhcl_pkg::ST_RENEWING || st == dhcl_pkg::ST_REBINDING) ?
                            dhcl_pkg::EV_RENEW : dhcl_pkg::EV_BOUND;
                        st     = dhcl_pkg::ST_BOUND;
                        listen = dhcl_pkg::LM_NONE;
                    end else if (it.message_kind == dhcl_pkg::MK_NAK) begin
                        reply.script_kind = (st == dhcl_pkg::ST_REQUESTING) ?
                                            dhcl_pkg::EV_NAK : dhcl_pkg::EV_NAK_DECONFIG;
                        want_ip = '0;
                        to_selecting(it.now_seconds);
                    end
                end
                default: ;
            endcase
        endfunction

        function void on_renew();
            case (st)
                dhcl_pkg::ST_BOUND: begin
                    listen = dhcl_pkg::LM_KERNEL;
                    st = dhcl_pkg::ST_RENEW_REQ;
                end
                dhcl_pkg::ST_RENEWING, dhcl_pkg::ST_REBINDING: st = dhcl_pkg::ST_RENEW_REQ;
                dhcl_pkg::ST_RENEW_REQ: begin
                    reply.script_kind = dhcl_pkg::EV_DECONFIG;
                    listen = dhcl_pkg::LM_RAW;
                    st = dhcl_pkg::ST_SELECTING;
                end
                dhcl_pkg::ST_REQUESTING, dhcl_pkg::ST_RELEASED: begin
                    listen = dhcl_pkg::LM_RAW;
                    st = dhcl_pkg::ST_SELECTING;
                end
                default: ;
            endcase
            tries = '0;
            deadline = '0;
        endfunction

        function void on_release(logic [31:0] fresh);
            if (st == dhcl_pkg::ST_BOUND || st == dhcl_pkg::ST_RENEWING
                || st == dhcl_pkg::ST_REBINDING) begin
                emit(dhcl_pkg::SK_RELEASE, fresh, srv_addr, want_ip);
                reply.script_kind = dhcl_pkg::EV_DECONFIG;
            end
            listen = dhcl_pkg::LM_NONE;
            st = dhcl_pkg::ST_RELEASED;
            deadline = dhcl_pkg::RELEASED_WAIT;
        endfunction

        // Step the client on an accepted event and queue the reply it owes
        function void note_event(dhcl_pkg::t_item it);
            reply = '0;
            emit(dhcl_pkg::SK_NONE, '0, '0, '0);
            reply.script_kind = dhcl_pkg::EV_NONE;
            reply.lease_exhausted = 1'b0;
            case (it.opcode)
                dhcl_pkg::OP_TICK:   on_tick(it.now_seconds, it.fresh_id);
                dhcl_pkg::OP_PACKET: on_packet(it);
                dhcl_pkg::OP_RENEW:  on_renew();
                default:             on_release(it.fresh_id);
            endcase
            reply.client_state  = st;
            reply.sock_mode     = listen;
            reply.lease_seconds = lease_len;
            replies.push_back(reply);
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        endfunction

        // Compare a reply beat with the oldest one owed
        function void check_reply(dhcl_pkg::t_result got);
            dhcl_pkg::t_result want;
            if (replies.size() == 0) begin
                $display("%0t: reply beat with nothing owed, expected none, got send_kind %0d",
                         $time, got.send_kind);
                mismatches++;
                return;
            end
            want = replies.pop_front();
            if (got.send_kind !== want.send_kind)
                flag("send_kind", 32'(want.send_kind), 32'(got.send_kind));
            if (got.send_id !== want.send_id) flag("send_id", want.send_id, got.send_id);
            if (got.send_server !== want.send_server)
                flag("send_server", want.send_server, got.send_server);
            if (got.send_address !== want.send_address)
                flag("send_address", want.send_address, got.send_address);
            if (got.script_kind !== want.script_kind)
                flag("script_kind", 32'(want.script_kind), 32'(got.script_kind));
            if (got.client_state !== want.client_state)
                flag("client_state", 32'(want.client_state), 32'(got.client_state));
            if (got.sock_mode !== want.sock_mode)
                flag("sock_mode", 32'(want.sock_mode), 32'(got.sock_mode));
            if (got.lease_seconds !== want.lease_seconds)
                flag("lease_seconds", want.lease_seconds, got.lease_seconds);
            if (got.lease_exhausted !== want.lease_exhausted)
                flag("lease_exhausted", 32'(want.lease_exhausted), 32'(got.lease_exhausted));
        endfunction
    endclass

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic [dhcl_pkg::IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [1:0]                       i_s_tuser   = '0;
    logic                             i_s_tvalid  = 1'b0;
    logic                             o_s_tready;
    logic [dhcl_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic [2:0]                       o_m_tuser;
    logic                             o_m_tvalid;
    logic                             i_m_tready  = 1'b0;
    logic [31:0]                      i_cfg_data  = '0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;

    lease_tracker       sb;
    logic [31:0]        last_now   = '0;
    logic               calm       = 1'b0;
    int                 tick_pct   = 50;
    int                 stall_left = 0;
    int                 cycles     = 0;
    dhcl_pkg::t_result  seen;

    dhcp_client_lease_fsm dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_data  (i_cfg_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("dhcp_client_lease_fsm_tb: done, errors");
            $finish;
        end
    end

    // Stall the reply side at random, short stalls mostly
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                          : $urandom_range(1, 3);
        end
    end

    // Check each reply beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.send_kind       = dhcl_pkg::t_send'(o_m_tuser);
            seen.send_id         = o_m_tdata[31:0];
            seen.send_server     = o_m_tdata[63:32];
            seen.send_address    = o_m_tdata[95:64];
            seen.script_kind     = dhcl_pkg::t_event'(o_m_tdata[98:96]);
            seen.client_state    = dhcl_pkg::t_state'(o_m_tdata[101:99]);
            seen.sock_mode       = dhcl_pkg::t_listen'(o_m_tdata[103:102]);
            seen.lease_seconds   = o_m_tdata[135:104];
            seen.lease_exhausted = o_m_tdata[136];
            sb.check_reply(seen);
        end
    end

    function automatic logic [31:0] pick_lease();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 40);
            3, 4, 5: return $urandom_range(1000, 200000);
            6: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return LEASE_GRAIN * $urandom_range(1, 4);
                    default: return LEASE_GRAIN * $urandom_range(1, 4) - 32'd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Every field random; callers pin the ones that matter
    function automatic dhcl_pkg::t_item any_event(dhcl_pkg::t_opcode op);
        dhcl_pkg::t_item it;
        it.opcode          = op;
        it.now_seconds     = $urandom;
        it.fresh_id        = $urandom;
        it.packet_id       = $urandom;
        it.message_kind    = 3'($urandom_range(0, 7));
        it.has_server_id   = 1'($urandom_range(0, 1));
        it.server_id       = $urandom;
        it.offered_address = $urandom;
        it.has_lease       = 1'($urandom_range(0, 1));
        it.lease_option    = $urandom;
        return it;
    endfunction

    function automatic dhcl_pkg::t_item tick_at(logic [31:0] now);
        dhcl_pkg::t_item it;
        it = any_event(dhcl_pkg::OP_TICK);
        it.now_seconds = now;
        last_now = now;
        return it;
    endfunction

    function automatic dhcl_pkg::t_item reply_packet(logic [2:0] kind, logic [31:0] pid);
        dhcl_pkg::t_item it;
        it = any_event(dhcl_pkg::OP_PACKET);
        it.now_seconds   = last_now + $urandom_range(0, 3);
        it.packet_id     = pid;
        it.message_kind  = kind;
        it.has_server_id = ($urandom_range(0, 7) != 0);
        it.has_lease     = ($urandom_range(0, 5) != 0);
        it.lease_option  = pick_lease();
        return it;
    endfunction

    // Mostly well-formed exchanges against the tracked client, some noise
    function automatic dhcl_pkg::t_item random_event();
        logic [31:0] pid;
        logic [2:0]  kind;
        int          r;
        int          w;
        r = $urandom_range(0, 99);
        if (r < tick_pct) begin
            w = $urandom_range(0, 19);
            if (w < 14)      return tick_at(sb.deadline + $urandom_range(0, 3));
            else if (w < 17) return tick_at(sb.deadline - 32'd1 - $urandom_range(0, 4));
            else             return tick_at($urandom);
        end else if (r < tick_pct + 35) begin
            pid = ($urandom_range(0, 9) != 0) ? sb.trans_id : $urandom;
            w = $urandom_range(0, 19);
            if (w < 2)
                kind = 3'($urandom_range(0, 7));
            else if (sb.st == dhcl_pkg::ST_SELECTING)
                kind = (w < 17) ? dhcl_pkg::MK_OFFER : dhcl_pkg::MK_ACK;
            else if (w < 13)
                kind = dhcl_pkg::MK_ACK;
            else if (w < 17)
                kind = dhcl_pkg::MK_NAK;
            else
                kind = dhcl_pkg::MK_OFFER;
            return reply_packet(kind, pid);
        end else if (r < tick_pct + 44) begin
            return any_event(dhcl_pkg::OP_RENEW);
        end
        return any_event(dhcl_pkg::OP_RELEASE);
    endfunction

    function automatic int pick_gap();
        if (calm) return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7, 8:    return $urandom_range(1, 3);
            default:       return $urandom_range(5, 30);
        endcase
    endfunction

    // Drive one event beat and hold it until taken
    task automatic push_event(input dhcl_pkg::t_item it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata <= {3'b000, it.lease_option, it.has_lease, it.offered_address,
                      it.server_id, it.has_server_id, it.message_kind, it.packet_id,
                      it.fresh_id, it.now_seconds};
        i_s_tuser  <= it.opcode;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_event(it);
    endtask

    // Drop valid and wait until every owed reply is in
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_request_ip(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_request_ip(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        dhcl_pkg::t_item it;
        logic [31:0] ip_values[PHASES];
        sb = new();
        ip_values[0] = '1;
        ip_values[1] = '0;
        ip_values[2] = $urandom;
        ip_values[3] = $urandom;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_request_ip(ip_values[0]);

        // Discover retries, the early tick, and the exhausted wait
        push_event(tick_at('0));
        push_event(tick_at(sb.deadline - 32'd1));
        push_event(tick_at(sb.deadline));
        push_event(tick_at(sb.deadline));
        push_event(tick_at(sb.deadline));
        push_event(tick_at(sb.deadline));
        // Ignored replies: wrong id, no type option, offer without server id
        push_event(reply_packet(dhcl_pkg::MK_OFFER, ~sb.trans_id));
        push_event(reply_packet(dhcl_pkg::MK_ABSENT, sb.trans_id));
        it = reply_packet(dhcl_pkg::MK_OFFER, sb.trans_id);
        it.has_server_id = 1'b0;
        push_event(it);
        // Accepted offer with all-ones fields, then request and default lease
        it = reply_packet(dhcl_pkg::MK_OFFER, sb.trans_id);
        it.has_server_id   = 1'b1;
        it.server_id       = '1;
        it.offered_address = '1;
        push_event(it);
        push_event(tick_at(sb.deadline));
        it = reply_packet(dhcl_pkg::MK_ACK, sb.trans_id);
        it.has_lease = 1'b0;
        push_event(it);
        // Bound listens to nothing
        push_event(reply_packet(dhcl_pkg::MK_ACK, sb.trans_id));
        push_event(tick_at(sb.deadline));
        // Renewal ack with the widest lease
        it = reply_packet(dhcl_pkg::MK_ACK, sb.trans_id);
        it.has_lease    = 1'b1;
        it.lease_option = '1;
        push_event(it);
        push_event(any_event(dhcl_pkg::OP_RENEW));
        push_event(tick_at(sb.deadline));
        push_event(any_event(dhcl_pkg::OP_RENEW));
        // Tiny lease runs straight through rebinding to a deconfig
        push_event(tick_at(sb.deadline));
        it = reply_packet(dhcl_pkg::MK_OFFER, sb.trans_id);
        it.has_server_id = 1'b1;
        push_event(it);
        push_event(tick_at(sb.deadline));
        it = reply_packet(dhcl_pkg::MK_ACK, sb.trans_id);
        it.has_lease    = 1'b1;
        it.lease_option = 32'd1;
        push_event(it);
        push_event(tick_at(sb.deadline));
        push_event(tick_at(sb.deadline));
        // Release without a lease, the released wait, and back out
        push_event(any_event(dhcl_pkg::OP_RELEASE));
        push_event(tick_at(dhcl_pkg::RELEASED_WAIT));
        push_event(any_event(dhcl_pkg::OP_RENEW));

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                write_request_ip(ip_values[p]);
            end
            tick_pct = (p % 2 == 0) ? 45 + 10 * p : 40 + 5 * p;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
                push_event(random_event());
            end
        end

        calm = 1'b0;
        drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.replies.size() == 0) begin
            $display("dhcp_client_lease_fsm_tb: done, clean");
        end else begin
            $display("dhcp_client_lease_fsm_tb: done, errors");
        end
        $finish;
    end

endmodule
